// ----- hdl/qtr_pkg.sv -----
package qtr_pkg;

  localparam int DATA_WIDTH = 16;

  // matrix entries, row major: m00 m01 m02 m10 m11 m12 m20 m21 m22
  localparam int LANES = 9;

  // entries that read 1.0 in the identity matrix
  localparam logic [LANES-1:0] DIAG_MASK = 9'b1_0001_0001;

  localparam int FIFO_DEPTH = 4;

endpackage

// ----- hdl/qtr_if.sv -----
interface qtr_in_if #(
  parameter int DATA_WIDTH = qtr_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] quat_w;

  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink (input valid, input quat_x, input quat_y, input quat_z,
                input quat_w, output ready);
endinterface

interface qtr_out_if #(
  parameter int DATA_WIDTH = qtr_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] m00;
  logic signed [DATA_WIDTH-1:0] m01;
  logic signed [DATA_WIDTH-1:0] m02;
  logic signed [DATA_WIDTH-1:0] m10;
  logic signed [DATA_WIDTH-1:0] m11;
  logic signed [DATA_WIDTH-1:0] m12;
  logic signed [DATA_WIDTH-1:0] m20;
  logic signed [DATA_WIDTH-1:0] m21;
  logic signed [DATA_WIDTH-1:0] m22;
  logic                         degenerate;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  output degenerate, input ready);
  modport sink (input valid, input m00, input m01, input m02, input m10,
                input m11, input m12, input m20, input m21, input m22,
                input degenerate, output ready);
endinterface

// ----- hdl/qtr_front.sv -----
module qtr_front #(
  parameter int DATA_WIDTH = qtr_pkg::DATA_WIDTH
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]                  quat_x,
  input  logic signed [DATA_WIDTH-1:0]                  quat_y,
  input  logic signed [DATA_WIDTH-1:0]                  quat_z,
  input  logic signed [DATA_WIDTH-1:0]                  quat_w,
  output logic                                          job_valid,
  input  logic                                          job_ready,
  output logic [2*DATA_WIDTH:0]                         job_norm,
  output logic [qtr_pkg::LANES-1:0][2*DATA_WIDTH:0]     job_num,
  output logic [qtr_pkg::LANES-1:0]                     job_neg,
  output logic                                          job_degen
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = PW + 1;
  localparam int NW = PW + 1;

  function automatic logic [NW-1:0] diag_mag(logic signed [SW-1:0] a,
                                             logic signed [SW-1:0] b);
    logic signed [SW-1:0] d;
    d = (a < b) ? (b - a) : (a - b);
    return NW'(d);
  endfunction

  // twice the magnitude, so off-diagonal entries share the diagonal divider
  function automatic logic [NW-1:0] off_mag(logic signed [SW-1:0] o);
    logic [SW-1:0] m;
    m = o[SW-1] ? SW'(-o) : SW'(o);
    return {m[NW-2:0], 1'b0};
  endfunction

  logic [2:0] vld_r;
  logic       en;

  logic signed [PW-1:0] p_xx_r, p_yy_r, p_zz_r, p_ww_r;
  logic signed [PW-1:0] p_xy_r, p_xz_r, p_yz_r, p_wx_r, p_wy_r, p_wz_r;
  logic                 deg1_r;

  logic signed [SW-1:0] s_xw_r, s_yz_r, s_yw_r, s_xz_r, s_zw_r, s_xy_r;
  logic signed [SW-1:0] o01_r, o02_r, o10_r, o12_r, o20_r, o21_r;
  logic                 deg2_r;

  logic [NW-1:0]                         norm_r;
  logic [qtr_pkg::LANES-1:0][NW-1:0]     num_r, num_nxt;
  logic [qtr_pkg::LANES-1:0]             neg_r, neg_nxt;
  logic                                  deg3_r;

  assign en       = !vld_r[2] || job_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_comb begin
    num_nxt[0] = diag_mag(s_xw_r, s_yz_r);
    neg_nxt[0] = s_xw_r < s_yz_r;
    num_nxt[1] = off_mag(o01_r);
    neg_nxt[1] = o01_r[SW-1];
    num_nxt[2] = off_mag(o02_r);
    neg_nxt[2] = o02_r[SW-1];
    num_nxt[3] = off_mag(o10_r);
    neg_nxt[3] = o10_r[SW-1];
    num_nxt[4] = diag_mag(s_yw_r, s_xz_r);
    neg_nxt[4] = s_yw_r < s_xz_r;
    num_nxt[5] = off_mag(o12_r);
    neg_nxt[5] = o12_r[SW-1];
    num_nxt[6] = off_mag(o20_r);
    neg_nxt[6] = o20_r[SW-1];
    num_nxt[7] = off_mag(o21_r);
    neg_nxt[7] = o21_r[SW-1];
    num_nxt[8] = diag_mag(s_zw_r, s_xy_r);
    neg_nxt[8] = s_zw_r < s_xy_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      p_xx_r <= quat_x * quat_x;
      p_yy_r <= quat_y * quat_y;
      p_zz_r <= quat_z * quat_z;
      p_ww_r <= quat_w * quat_w;
      p_xy_r <= quat_x * quat_y;
      p_xz_r <= quat_x * quat_z;
      p_yz_r <= quat_y * quat_z;
      p_wx_r <= quat_w * quat_x;
      p_wy_r <= quat_w * quat_y;
      p_wz_r <= quat_w * quat_z;
      deg1_r <= (quat_x == '0) && (quat_y == '0) && (quat_z == '0) && (quat_w == '0);

      // pair sums
      s_xw_r <= SW'(p_xx_r) + SW'(p_ww_r);
      s_yz_r <= SW'(p_yy_r) + SW'(p_zz_r);
      s_yw_r <= SW'(p_yy_r) + SW'(p_ww_r);
      s_xz_r <= SW'(p_xx_r) + SW'(p_zz_r);
      s_zw_r <= SW'(p_zz_r) + SW'(p_ww_r);
      s_xy_r <= SW'(p_xx_r) + SW'(p_yy_r);
      o01_r  <= SW'(p_xy_r) - SW'(p_wz_r);
      o02_r  <= SW'(p_xz_r) + SW'(p_wy_r);
      o10_r  <= SW'(p_xy_r) + SW'(p_wz_r);
      o12_r  <= SW'(p_yz_r) - SW'(p_wx_r);
      o20_r  <= SW'(p_xz_r) - SW'(p_wy_r);
      o21_r  <= SW'(p_yz_r) + SW'(p_wx_r);
      deg2_r <= deg1_r;

      // norm and numerator magnitudes
      norm_r <= NW'(s_xy_r) + NW'(s_zw_r);
      num_r  <= num_nxt;
      neg_r  <= neg_nxt;
      deg3_r <= deg2_r;
    end
  end

  assign job_valid = vld_r[2];
  assign job_norm  = norm_r;
  assign job_num   = num_r;
  assign job_neg   = neg_r;
  assign job_degen = deg3_r;

endmodule

// ----- hdl/qtr_fifo.sv -----
module qtr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = qtr_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/qtr_back.sv -----
module qtr_back #(
  parameter int DATA_WIDTH = qtr_pkg::DATA_WIDTH
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          job_valid,
  output logic                                          job_ready,
  input  logic [2*DATA_WIDTH:0]                         job_norm,
  input  logic [qtr_pkg::LANES-1:0][2*DATA_WIDTH:0]     job_num,
  input  logic [qtr_pkg::LANES-1:0]                     job_neg,
  input  logic                                          job_degen,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [qtr_pkg::LANES-1:0][DATA_WIDTH-1:0]     out_mat,
  output logic                                          out_degen
);

  localparam int QW = DATA_WIDTH;
  localparam int NW = 2 * DATA_WIDTH + 1;
  localparam logic [QW-1:0] ONE     = {2'b01, {(QW - 2){1'b0}}};
  localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW - 1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW - 1){1'b0}}};

  logic                                  en;
  logic [QW-1:0]                         vld_r;
  logic [NW-1:0]                         norm_r [QW];
  logic [qtr_pkg::LANES-1:0]             neg_r  [QW];
  logic [QW-1:0]                         deg_r;
  logic [qtr_pkg::LANES-1:0][NW-1:0]     rem_r  [QW];
  logic [qtr_pkg::LANES-1:0][NW-1:0]     rem_nxt [QW];
  logic [qtr_pkg::LANES-1:0][QW-1:0]     quo_r  [QW];
  logic [qtr_pkg::LANES-1:0][QW-1:0]     quo_nxt [QW];

  logic                                  out_valid_r;
  logic [qtr_pkg::LANES-1:0][QW-1:0]     mat_r, mat_nxt;
  logic                                  deg_out_r;

  assign en        = !out_valid_r || out_ready;
  assign job_ready = en;

  // one quotient bit per stage, integer bit first
  always_comb begin
    logic [NW:0] dbl;
    logic        ge;
    for (int l = 0; l < qtr_pkg::LANES; l++) begin
      ge            = job_num[l] >= job_norm;
      rem_nxt[0][l] = ge ? (job_num[l] - job_norm) : job_num[l];
      quo_nxt[0][l] = {{(QW - 1){1'b0}}, ge};
    end
    for (int s = 1; s < QW; s++) begin
      for (int l = 0; l < qtr_pkg::LANES; l++) begin
        dbl           = {rem_r[s-1][l], 1'b0};
        ge            = dbl >= {1'b0, norm_r[s-1]};
        rem_nxt[s][l] = ge ? NW'(dbl - {1'b0, norm_r[s-1]}) : dbl[NW-1:0];
        quo_nxt[s][l] = {quo_r[s-1][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r[0] <= job_norm;
      neg_r[0]  <= job_neg;
      deg_r[0]  <= job_degen;
      for (int s = 1; s < QW; s++) begin
        norm_r[s] <= norm_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        deg_r[s]  <= deg_r[s-1];
      end
      for (int s = 0; s < QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  // round half away from zero, saturate, apply sign; a degenerate job gives the identity matrix
  always_comb begin
    logic [QW:0]   rnd;
    logic [QW-1:0] mag;
    logic [QW-1:0] sat;
    for (int l = 0; l < qtr_pkg::LANES; l++) begin
      rnd = {1'b0, quo_r[QW-1][l]} + 1'b1;
      mag = rnd[QW:1];
      if (neg_r[QW-1][l]) begin
        sat        = (mag > NEG_LIM) ? NEG_LIM : mag;
        mat_nxt[l] = ~sat + 1'b1;
      end else begin
        sat        = (mag > POS_LIM) ? POS_LIM : mag;
        mat_nxt[l] = sat;
      end
      if (deg_r[QW-1]) begin
        mat_nxt[l] = qtr_pkg::DIAG_MASK[l] ? ONE : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat_r     <= mat_nxt;
      deg_out_r <= deg_r[QW-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_mat   = mat_r;
  assign out_degen = deg_out_r;

endmodule

// ----- hdl/quaternion_to_rotation_matrix.sv -----
// channel   direction  fields                              handshake
// in_quat   in         quat_x quat_y quat_z quat_w         valid / ready
// out_mat   out        m00 .. m22, degenerate              valid / ready
//
// one quaternion per cycle sustained while out_mat is ready; the pipeline runs through
// three front stages (products, pair sums, norm), the queue,
// DATA_WIDTH divider stages of one quotient bit each, one rounding stage
// a four-entry queue separates the front from the divider, so each stalls alone
// synchronous active-low reset empties the pipeline and the queue
module quaternion_to_rotation_matrix #(
  parameter int DATA_WIDTH = qtr_pkg::DATA_WIDTH
) (
  input logic        clk,
  input logic        rst_n,
  qtr_in_if.sink     in_quat,
  qtr_out_if.source  out_mat
);

  localparam int NW = 2 * DATA_WIDTH + 1;
  localparam int JW = NW + qtr_pkg::LANES * NW + qtr_pkg::LANES + 1;

  logic                                      f_valid, f_ready;
  logic [NW-1:0]                             f_norm;
  logic [qtr_pkg::LANES-1:0][NW-1:0]         f_num;
  logic [qtr_pkg::LANES-1:0]                 f_neg;
  logic                                      f_degen;

  logic                                      b_valid, b_ready;
  logic [JW-1:0]                             push_data, pop_data;
  logic [NW-1:0]                             b_norm;
  logic [qtr_pkg::LANES-1:0][NW-1:0]         b_num;
  logic [qtr_pkg::LANES-1:0]                 b_neg;
  logic                                      b_degen;

  logic [qtr_pkg::LANES-1:0][DATA_WIDTH-1:0] mat;

  qtr_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_quat.valid),
    .in_ready  (in_quat.ready),
    .quat_x    (in_quat.quat_x),
    .quat_y    (in_quat.quat_y),
    .quat_z    (in_quat.quat_z),
    .quat_w    (in_quat.quat_w),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_norm  (f_norm),
    .job_num   (f_num),
    .job_neg   (f_neg),
    .job_degen (f_degen)
  );

  assign push_data = {f_degen, f_neg, f_num, f_norm};

  qtr_fifo #(
    .WIDTH (JW),
    .DEPTH (qtr_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (push_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (pop_data)
  );

  assign b_norm  = pop_data[NW-1:0];
  assign b_num   = pop_data[NW +: qtr_pkg::LANES * NW];
  assign b_neg   = pop_data[NW + qtr_pkg::LANES * NW +: qtr_pkg::LANES];
  assign b_degen = pop_data[JW-1];

  qtr_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job_norm  (b_norm),
    .job_num   (b_num),
    .job_neg   (b_neg),
    .job_degen (b_degen),
    .out_valid (out_mat.valid),
    .out_ready (out_mat.ready),
    .out_mat   (mat),
    .out_degen (out_mat.degenerate)
  );

  assign out_mat.m00 = mat[0];
  assign out_mat.m01 = mat[1];
  assign out_mat.m02 = mat[2];
  assign out_mat.m10 = mat[3];
  assign out_mat.m11 = mat[4];
  assign out_mat.m12 = mat[5];
  assign out_mat.m20 = mat[6];
  assign out_mat.m21 = mat[7];
  assign out_mat.m22 = mat[8];

endmodule
